[src/dswpw_pkg.sv]
package dswpw_pkg;

  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_PAGE     = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  localparam logic [1:0] FMT_WORD   = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;

  localparam logic REQ_WINDOW = 1'b0;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] WIN_LAST_STEP  = 4'd10;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd2;

  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_FORMAT = 1'b0;

  typedef struct packed {
    logic        req_type;
    logic [15:0] win_x;
    logic [15:0] win_y;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic [23:0] pixel_in;
  } item_t;

  typedef struct packed {
    logic [15:0] data;
    logic        wide;
    logic        dc;
    logic        frame_end;
    logic        last;
  } res_t;

endpackage

[src/dswpw_seq.sv]
module dswpw_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dswpw_pkg::item_t in_item,
  input  logic [1:0]       pixel_format,
  input  logic             res_ready,
  output logic             res_valid,
  output dswpw_pkg::res_t  res
);
  import dswpw_pkg::*;

  logic              item_v_r, item_v_nxt;
  item_t             item_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [31:0]       pix_left_r, pix_left_nxt;

  logic              is_win, drop, fire, done, accept, at_last;
  logic [STEP_W-1:0] last_step;
  logic [15:0]       x_end, y_end;
  logic [7:0]        px_byte;
  logic              px_fend;

  assign is_win    = item_r.req_type == REQ_WINDOW;
  assign drop      = !is_win && (pix_left_r == 32'd0);
  assign last_step = is_win ? WIN_LAST_STEP :
                     (pixel_format == FMT_WORD) ? '0 : BYTE_LAST_STEP;
  assign at_last   = step_r == last_step;
  assign res_valid = item_v_r && !drop;
  assign fire      = res_valid && res_ready;
  assign done      = item_v_r && (drop || (res_ready && at_last));
  assign in_stall  = item_v_r && !done;
  assign accept    = in_valid && !in_stall;

  assign x_end   = item_r.win_x + item_r.win_width - 16'd1;
  assign y_end   = item_r.win_y + item_r.win_height - 16'd1;
  assign px_fend = pix_left_r == 32'd1;

  always_comb begin
    px_byte = 8'h00;
    if (pixel_format == FMT_RGB565) begin
      case (step_r[1:0])
        2'd0:    px_byte = {item_r.pixel_in[4:0], 3'b000};
        2'd1:    px_byte = {item_r.pixel_in[10:5], 2'b00};
        default: px_byte = {item_r.pixel_in[15:11], 3'b000};
      endcase
    end else begin
      case (step_r[1:0])
        2'd0:    px_byte = item_r.pixel_in[23:16];
        2'd1:    px_byte = item_r.pixel_in[15:8];
        default: px_byte = item_r.pixel_in[7:0];
      endcase
    end
  end

  always_comb begin
    res = '{data: 16'h0000, wide: 1'b0, dc: 1'b1, frame_end: 1'b0, last: 1'b0};
    if (is_win) begin
      case (step_r)
        4'd0:    res.data = {8'h00, CMD_COLUMN};
        4'd1:    res.data = {8'h00, item_r.win_x[15:8]};
        4'd2:    res.data = {8'h00, item_r.win_x[7:0]};
        4'd3:    res.data = {8'h00, x_end[15:8]};
        4'd4:    res.data = {8'h00, x_end[7:0]};
        4'd5:    res.data = {8'h00, CMD_PAGE};
        4'd6:    res.data = {8'h00, item_r.win_y[15:8]};
        4'd7:    res.data = {8'h00, item_r.win_y[7:0]};
        4'd8:    res.data = {8'h00, y_end[15:8]};
        4'd9:    res.data = {8'h00, y_end[7:0]};
        default: res.data = {8'h00, CMD_MEMWRITE};
      endcase
      res.dc        = !(step_r == 4'd0 || step_r == 4'd5 || at_last);
      // address frames close after their end-low byte; 0x2C closes only if empty
      res.frame_end = step_r == 4'd4 || step_r == 4'd9 ||
                      (at_last && pix_left_r == 32'd0);
      res.last      = at_last;
    end else if (pixel_format == FMT_WORD) begin
      res.data      = item_r.pixel_in[15:0];
      res.wide      = 1'b1;
      res.frame_end = px_fend;
      res.last      = 1'b1;
    end else begin
      res.data      = {8'h00, px_byte};
      res.frame_end = at_last && px_fend;
      res.last      = at_last;
    end
  end

  always_comb begin
    item_v_nxt   = item_v_r;
    step_nxt     = step_r;
    pix_left_nxt = pix_left_r;
    if (fire && is_win && step_r == '0) begin
      pix_left_nxt = 32'(item_r.win_width) * 32'(item_r.win_height);
    end else if (fire && !is_win && at_last) begin
      pix_left_nxt = pix_left_r - 32'd1;
    end
    if (accept) begin
      item_v_nxt = 1'b1;
      step_nxt   = '0;
    end else if (done) begin
      item_v_nxt = 1'b0;
    end else if (fire) begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r   <= 1'b0;
      step_r     <= '0;
      pix_left_r <= 32'd0;
    end else begin
      item_v_r   <= item_v_nxt;
      step_r     <= step_nxt;
      pix_left_r <= pix_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

endmodule

[src/dbi_serial_window_pixel_writer.sv]
// After its input transfer, the first result of an item passes through the item
// register, then the result register.
// Throughput: one result per cycle while out_stall is low; a window gives 11 results,
// a pixel 1 result in 16-bit word format or 3 results in the byte formats.
// A pixel with no open window is dropped without a result.
// Reset (rst_n, synchronous): empties the item and result registers, clears
// the pixel counter and sets pixel_format to 0.
module dbi_serial_window_pixel_writer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [15:0]                  in_win_x,
  input  logic [15:0]                  in_win_y,
  input  logic [15:0]                  in_win_width,
  input  logic [15:0]                  in_win_height,
  input  logic [23:0]                  in_pixel_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_data,
  output logic                         out_wide,
  output logic                         out_dc_flag,
  output logic                         out_frame_end,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dswpw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import dswpw_pkg::*;

  logic [1:0] fmt_r;
  logic       out_v_r;
  res_t       out_r;
  item_t      in_item;
  logic       res_ready, res_valid;
  res_t       res;

  assign in_item = '{req_type: in_req_type, win_x: in_win_x, win_y: in_win_y,
                     win_width: in_win_width, win_height: in_win_height,
                     pixel_in: in_pixel_in};

  // register transfer on the access cycle; only index 0 exists
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FORMAT) ? {30'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_WORD;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_FORMAT) begin
      fmt_r <= pwdata[1:0];
    end
  end

  dswpw_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .pixel_format (fmt_r),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res)
  );

  assign res_ready = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (res_ready) begin
      out_v_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_data      = out_r.data;
  assign out_wide      = out_r.wide;
  assign out_dc_flag   = out_r.dc;
  assign out_frame_end = out_r.frame_end;
  assign out_last      = out_r.last;

endmodule
